>>> rtl/core/taa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taa_pkg: shared types and constants of the transformed box accumulator
// Coordinate and product types, configuration layout, queue sizing and the
// rounding/saturation helpers used by the front pipeline.
// ----------------------------------------------------------------------------
package taa_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int NUM_AXES  = 3;
	localparam int NUM_REGS  = 6;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int QDEPTH    = 8;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_XY     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_X_Z_OFS  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_Y_XY     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_Y_Z_OFS  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_Z_XY     = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_Z_Z_OFS  = CFG_IDX_W'(5);

	localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	localparam coord_t POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam sum_t   ROUND_HALF = sum_t'(1) <<< (FRAC_W - 1);

	// Input item; packs as {use_transform, restart, box max, box min}
	typedef struct packed {
		logic                    use_transform;
		logic                    restart;
		coord_t [NUM_AXES-1:0]   bmax;
		coord_t [NUM_AXES-1:0]   bmin;
	} item_t;

	// Classified candidate bounds for the fold stage
	typedef struct packed {
		logic                    restart;
		coord_t [NUM_AXES-1:0]   hi;
		coord_t [NUM_AXES-1:0]   lo;
	} cand_t;

	// Running box; packs as {max, min}
	typedef struct packed {
		coord_t [NUM_AXES-1:0]   hi;
		coord_t [NUM_AXES-1:0]   lo;
	} bounds_t;

	typedef struct packed {
		logic                    nonempty;
		logic [QCNT_W-1:0]       level;
	} qstat_t;

	function automatic prod_t mul_q16(input coord_t a, input coord_t b);
		return prod_t'(a) * prod_t'(b);
	endfunction

	// Drop the low 16 fraction bits of a rounded Q34.32 sum and clamp to 32 bits
	function automatic coord_t sat_q16(input sum_t s);
		logic [SUM_W-FRAC_W-COORD_W:0] top;
		top = s[SUM_W-1:FRAC_W+COORD_W-1];
		if ((&top) || !(|top)) begin
			return s[FRAC_W+COORD_W-1:FRAC_W];
		end
		return s[SUM_W-1] ? NEG_MIN : POS_MAX;
	endfunction

endpackage

>>> rtl/core/taa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taa_front: configuration registers and transform pipeline
// Maps each box through the affine matrix (per-term min/max of the products)
// or orders its corners directly, and pushes candidate bounds to the queue.
// ----------------------------------------------------------------------------
module taa_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [taa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [taa_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	input  taa_pkg::item_t                 in_item,
	output logic                           push,
	output taa_pkg::cand_t                 push_data
);

	logic [taa_pkg::CFG_W-1:0] cfg_q [taa_pkg::NUM_REGS];

	taa_pkg::coord_t gain [taa_pkg::NUM_AXES][taa_pkg::NUM_AXES];
	taa_pkg::coord_t ofs  [taa_pkg::NUM_AXES];

	logic            v_s1, v_s2, v_s3, v_s4;
	taa_pkg::item_t  item_s1;
	logic            restart_s2, restart_s3, restart_s4;
	logic            xf_s2, xf_s3, xf_s4;
	taa_pkg::prod_t  pmin_s2 [taa_pkg::NUM_AXES][taa_pkg::NUM_AXES];
	taa_pkg::prod_t  pmax_s2 [taa_pkg::NUM_AXES][taa_pkg::NUM_AXES];
	taa_pkg::prod_t  tlo_s3  [taa_pkg::NUM_AXES][taa_pkg::NUM_AXES];
	taa_pkg::prod_t  thi_s3  [taa_pkg::NUM_AXES][taa_pkg::NUM_AXES];
	taa_pkg::sum_t   slo_s4  [taa_pkg::NUM_AXES];
	taa_pkg::sum_t   shi_s4  [taa_pkg::NUM_AXES];
	taa_pkg::coord_t dlo_s2  [taa_pkg::NUM_AXES];
	taa_pkg::coord_t dhi_s2  [taa_pkg::NUM_AXES];
	taa_pkg::coord_t dlo_s3  [taa_pkg::NUM_AXES];
	taa_pkg::coord_t dhi_s3  [taa_pkg::NUM_AXES];
	taa_pkg::coord_t dlo_s4  [taa_pkg::NUM_AXES];
	taa_pkg::coord_t dhi_s4  [taa_pkg::NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < taa_pkg::NUM_REGS; r++) begin
				cfg_q[r] <= taa_pkg::CFG_RESET[r];
			end
		end else if (cfg_we && (cfg_index <= taa_pkg::REG_Z_Z_OFS)) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	// Row a: gains in register 2a (x, y) and 2a+1 upper (z), offset in 2a+1 lower
	always_comb begin
		for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
			gain[a][0] = cfg_q[2*a][2*taa_pkg::COORD_W-1:taa_pkg::COORD_W];
			gain[a][1] = cfg_q[2*a][taa_pkg::COORD_W-1:0];
			gain[a][2] = cfg_q[2*a+1][2*taa_pkg::COORD_W-1:taa_pkg::COORD_W];
			ofs[a]     = cfg_q[2*a+1][taa_pkg::COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_s1    <= in_item;
		restart_s2 <= item_s1.restart;
		xf_s2      <= item_s1.use_transform;
		restart_s3 <= restart_s2;
		xf_s3      <= xf_s2;
		restart_s4 <= restart_s3;
		xf_s4      <= xf_s3;
		for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
			// direct path: order the two corners on this axis
			if ($signed(item_s1.bmin[a]) <= $signed(item_s1.bmax[a])) begin
				dlo_s2[a] <= item_s1.bmin[a];
				dhi_s2[a] <= item_s1.bmax[a];
			end else begin
				dlo_s2[a] <= item_s1.bmax[a];
				dhi_s2[a] <= item_s1.bmin[a];
			end
			dlo_s3[a] <= dlo_s2[a];
			dhi_s3[a] <= dhi_s2[a];
			dlo_s4[a] <= dlo_s3[a];
			dhi_s4[a] <= dhi_s3[a];
			for (int i = 0; i < taa_pkg::NUM_AXES; i++) begin
				pmin_s2[a][i] <= taa_pkg::mul_q16(gain[a][i], item_s1.bmin[i]);
				pmax_s2[a][i] <= taa_pkg::mul_q16(gain[a][i], item_s1.bmax[i]);
				// extreme corners pick the extreme term per input axis
				if (pmin_s2[a][i] <= pmax_s2[a][i]) begin
					tlo_s3[a][i] <= pmin_s2[a][i];
					thi_s3[a][i] <= pmax_s2[a][i];
				end else begin
					tlo_s3[a][i] <= pmax_s2[a][i];
					thi_s3[a][i] <= pmin_s2[a][i];
				end
			end
			slo_s4[a] <= taa_pkg::sum_t'(tlo_s3[a][0]) + taa_pkg::sum_t'(tlo_s3[a][1])
				+ taa_pkg::sum_t'(tlo_s3[a][2])
				+ taa_pkg::sum_t'($signed({ofs[a], {taa_pkg::FRAC_W{1'b0}}}))
				+ taa_pkg::ROUND_HALF;
			shi_s4[a] <= taa_pkg::sum_t'(thi_s3[a][0]) + taa_pkg::sum_t'(thi_s3[a][1])
				+ taa_pkg::sum_t'(thi_s3[a][2])
				+ taa_pkg::sum_t'($signed({ofs[a], {taa_pkg::FRAC_W{1'b0}}}))
				+ taa_pkg::ROUND_HALF;
		end
	end

	always_comb begin
		push              = v_s4;
		push_data.restart = restart_s4;
		for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
			push_data.lo[a] = xf_s4 ? taa_pkg::sat_q16(slo_s4[a]) : dlo_s4[a];
			push_data.hi[a] = xf_s4 ? taa_pkg::sat_q16(shi_s4[a]) : dhi_s4[a];
		end
	end

endmodule

>>> rtl/core/taa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taa_queue: candidate queue between front and back
// Small register FIFO; the top level's credit count keeps it from overflowing.
// ----------------------------------------------------------------------------
module taa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  taa_pkg::cand_t  push_data,
	input  logic            pop,
	output taa_pkg::cand_t  pop_data,
	output taa_pkg::qstat_t stat
);

	taa_pkg::cand_t                   mem_q [taa_pkg::QDEPTH];
	logic [taa_pkg::QPTR_W-1:0]       wr_q;
	logic [taa_pkg::QPTR_W-1:0]       rd_q;
	logic [taa_pkg::QCNT_W-1:0]       level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == taa_pkg::QPTR_W'(taa_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == taa_pkg::QPTR_W'(taa_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			level_q <= level_q + taa_pkg::QCNT_W'(push) - taa_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign pop_data      = mem_q[rd_q];
	assign stat.nonempty = (level_q != '0);
	assign stat.level    = level_q;

endmodule

>>> rtl/core/taa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taa_back: running box fold and output register
// Pops one candidate per cycle when the output slot is free, folds it into
// the running box and presents the updated box.
// ----------------------------------------------------------------------------
module taa_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_avail,
	input  taa_pkg::cand_t   q_data,
	input  logic             out_ready,
	output logic             pop,
	output logic             out_valid,
	output taa_pkg::bounds_t bound
);

	logic             valid_q;
	taa_pkg::bounds_t bound_q;

	assign pop = q_avail && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
				bound_q.lo[a] <= taa_pkg::POS_MAX;
				bound_q.hi[a] <= taa_pkg::NEG_MIN;
			end
		end else if (pop) begin
			valid_q <= 1'b1;
			for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
				// restart: drop the old box and take the candidate as is
				if (q_data.restart || ($signed(q_data.lo[a]) < $signed(bound_q.lo[a]))) begin
					bound_q.lo[a] <= q_data.lo[a];
				end
				if (q_data.restart || ($signed(q_data.hi[a]) > $signed(bound_q.hi[a]))) begin
					bound_q.hi[a] <= q_data.hi[a];
				end
			end
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign bound     = bound_q;

endmodule

>>> rtl/core/transformed_aabb_accumulate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_aabb_accumulate_core: running union of (transformed) boxes
// Folds one axis-aligned box per transfer into a running enclosing box,
// optionally mapping the box through a configured affine matrix first.
// ----------------------------------------------------------------------------
//   s_* carries one box per transfer; s_tuser flags restart (empty the running
//   box first) and use_transform (map all eight corners through the matrix).
//   m_* returns the running box after each box is folded in, one per input.
//   cfg_* writes one of the six 64-bit matrix registers; write them only while
//   no box is in flight.
// Path: a box passes four pipeline stages in the front, the candidate queue
//   and one fold in the back, and is shown when the output is free.
// Throughput: one box per cycle while m_tready is high; the fold of the running
//   min/max is the only loop.
// Stall: the front never stalls; a credit count of boxes in flight limits it
//   to what the candidate queue can hold, so s_tready drops once eight boxes
//   sit in the pipeline and queue while m_tready is low. m_* holds until taken.
// Reset: the matrix returns to identity and the running box to empty
//   (min at the most positive value, max at the most negative).
// ----------------------------------------------------------------------------
module transformed_aabb_accumulate_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic [taa_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [taa_pkg::CFG_W-1:0]              cfg_wdata,
	// input box stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  logic [6*taa_pkg::COORD_W-1:0]          s_tdata,
	// restart, use_transform
	input  logic [1:0]                             s_tuser,
	// running box stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// bound_min_x, bound_min_y, bound_min_z, bound_max_x, bound_max_y, bound_max_z
	output logic [6*taa_pkg::COORD_W-1:0]          m_tdata
);

	logic                        s_xfer;
	logic [taa_pkg::QCNT_W-1:0]  cnt_q;
	taa_pkg::item_t              item;
	logic                        push;
	taa_pkg::cand_t              push_data;
	logic                        pop;
	taa_pkg::cand_t              pop_data;
	taa_pkg::qstat_t             q_stat;
	taa_pkg::bounds_t            bound;

	// Credits: boxes in the front pipeline plus queued candidates
	assign s_tready = (cnt_q < taa_pkg::QCNT_W'(taa_pkg::QDEPTH));
	assign s_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + taa_pkg::QCNT_W'(s_xfer) - taa_pkg::QCNT_W'(pop);
		end
	end

	assign item = {s_tuser, s_tdata};

	taa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_xfer),
		.in_item   (item),
		.push      (push),
		.push_data (push_data)
	);

	taa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	taa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (q_stat.nonempty),
		.q_data    (pop_data),
		.out_ready (m_tready),
		.pop       (pop),
		.out_valid (m_tvalid),
		.bound     (bound)
	);

	assign m_tdata = bound;

`ifndef SYNTHESIS
	// credit count never exceeds queue capacity
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= taa_pkg::QCNT_W'(taa_pkg::QDEPTH))
		else $error("credit count above queue depth");

	// queued candidates are always covered by outstanding credits
	a_queue_in_credit: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= cnt_q)
		else $error("queue holds more than the credits in use");

	// any presented box has seen at least one fold, so min never exceeds max
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(bound.lo[0]) <= $signed(bound.hi[0]))
			&& ($signed(bound.lo[1]) <= $signed(bound.hi[1]))
			&& ($signed(bound.lo[2]) <= $signed(bound.hi[2])))
		else $error("running box min above max");

	// a pop with the output stalled would overwrite an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !pop)
		else $error("fold while result still pending");
`endif

endmodule

>>> sim/transformed_aabb_accumulate_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_aabb_accumulate_core_test: self-checking bench of the box union
// Streams boxes into the core with random gaps and output stalls. Each box is
// folded into a local running box, mapped through a local copy of the matrix
// when its transform flag is set. Every returned bound is then compared field
// by field. The matrix is rewritten between phases, while nothing is in flight.
// ----------------------------------------------------------------------------
module transformed_aabb_accumulate_core_test;

	// Write slots past the last matrix register; the core must ignore them
	localparam logic [taa_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = taa_pkg::CFG_IDX_W'(6);
	localparam logic [taa_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = taa_pkg::CFG_IDX_W'(7);

	// Wide enough for three full 32x32 products plus translation and rounding
	typedef logic signed [79:0] wide_t;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [taa_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [taa_pkg::CFG_W-1:0]           cfg_wdata = '0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	logic [6*taa_pkg::COORD_W-1:0]       s_tdata = '0;
	// restart, use_transform
	logic [1:0]                          s_tuser = '0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	// bound_min_x, bound_min_y, bound_min_z, bound_max_x, bound_max_y, bound_max_z
	logic [6*taa_pkg::COORD_W-1:0]       m_tdata;

	// Local view of the matrix and of the running box
	logic [taa_pkg::CFG_W-1:0]           coef [taa_pkg::NUM_REGS];
	taa_pkg::coord_t                     run_lo [taa_pkg::NUM_AXES];
	taa_pkg::coord_t                     run_hi [taa_pkg::NUM_AXES];

	taa_pkg::item_t                      pending_boxes [$];
	taa_pkg::bounds_t                    expected_bounds [$];
	int                                  mismatches = 0;
	bit                                  quiet = 1'b0;
	int                                  send_gap = 0;
	int                                  stall_left = 0;
	taa_pkg::item_t                      next_box;
	string                               axis_name [taa_pkg::NUM_AXES] = '{"x", "y", "z"};

	transformed_aabb_accumulate_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous ceiling on the whole run
	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic taa_pkg::coord_t pick_extreme();
		case ($urandom_range(0, 5))
			0: return taa_pkg::NEG_MIN;
			1: return taa_pkg::POS_MAX;
			2: return taa_pkg::coord_t'(0);
			3: return taa_pkg::coord_t'(-1);
			4: return taa_pkg::coord_t'(1);
			default: return taa_pkg::coord_t'(32'h0001_0000);
		endcase
	endfunction

	// mode 0: any 32-bit value, 1: within +-2.0, 2: corner values
	function automatic taa_pkg::coord_t rand_q16(input int mode);
		case (mode)
			0: return taa_pkg::coord_t'($urandom);
			1: return taa_pkg::coord_t'($urandom_range(0, 32'h0004_0000))
				- taa_pkg::coord_t'(32'h0002_0000);
			default: return pick_extreme();
		endcase
	endfunction

	// Coordinates: full range, within +-16.0 or corner values
	function automatic taa_pkg::coord_t rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return taa_pkg::coord_t'($urandom);
		if (r < 8) return taa_pkg::coord_t'($urandom_range(0, 32'h0020_0000))
			- taa_pkg::coord_t'(32'h0010_0000);
		return pick_extreme();
	endfunction

	// One mapped axis: exact Q32.32 sum, round half up, saturate to 32 bits
	function automatic taa_pkg::coord_t map_coord(input int axis,
			input taa_pkg::coord_t cx, input taa_pkg::coord_t cy,
			input taa_pkg::coord_t cz);
		logic [taa_pkg::CFG_W-1:0] r0;
		logic [taa_pkg::CFG_W-1:0] r1;
		wide_t                     acc;
		r0 = coef[2*axis];
		r1 = coef[2*axis+1];
		acc = wide_t'(taa_pkg::coord_t'(r0[63:32])) * wide_t'(cx)
			+ wide_t'(taa_pkg::coord_t'(r0[31:0])) * wide_t'(cy)
			+ wide_t'(taa_pkg::coord_t'(r1[63:32])) * wide_t'(cz)
			+ (wide_t'(taa_pkg::coord_t'(r1[31:0])) <<< taa_pkg::FRAC_W)
			+ wide_t'(32768);
		acc = acc >>> taa_pkg::FRAC_W;
		if (acc > wide_t'(taa_pkg::POS_MAX)) return taa_pkg::POS_MAX;
		if (acc < wide_t'(taa_pkg::NEG_MIN)) return taa_pkg::NEG_MIN;
		return taa_pkg::coord_t'(acc[taa_pkg::COORD_W-1:0]);
	endfunction

	// Fold one box into the local running box and return the new bounds
	function automatic taa_pkg::bounds_t fold_box(input taa_pkg::item_t it);
		taa_pkg::coord_t  corner [taa_pkg::NUM_AXES];
		taa_pkg::coord_t  mn;
		taa_pkg::coord_t  mx;
		taa_pkg::coord_t  v;
		taa_pkg::bounds_t res;
		if (it.restart) begin
			for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
				run_lo[a] = taa_pkg::POS_MAX;
				run_hi[a] = taa_pkg::NEG_MIN;
			end
		end
		if (it.use_transform) begin
			// every corner combination, reversed axes included
			for (int k = 0; k < 8; k++) begin
				for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
					corner[a] = ((k >> a) & 1) ? it.bmax[a] : it.bmin[a];
				end
				for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
					v = map_coord(a, corner[0], corner[1], corner[2]);
					if (v < run_lo[a]) run_lo[a] = v;
					if (v > run_hi[a]) run_hi[a] = v;
				end
			end
		end else begin
			for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
				mn = it.bmin[a];
				mx = it.bmax[a];
				// a reversed axis folds the smaller value into the min
				if (mn > mx) begin
					v = mn;
					mn = mx;
					mx = v;
				end
				if (mn < run_lo[a]) run_lo[a] = mn;
				if (mx > run_hi[a]) run_hi[a] = mx;
			end
		end
		for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
			res.lo[a] = run_lo[a];
			res.hi[a] = run_hi[a];
		end
		return res;
	endfunction

	// Driver: present the next pending box, predict at each transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_bounds.push_back(fold_box(taa_pkg::item_t'({s_tuser, s_tdata})));
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_boxes.size() != 0) begin
					next_box = pending_boxes.pop_front();
					s_tdata  <= {next_box.bmax, next_box.bmin};
					s_tuser  <= {next_box.use_transform, next_box.restart};
					s_tvalid <= 1'b1;
					send_gap = quiet ? 0 : gap_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		taa_pkg::bounds_t got;
		taa_pkg::bounds_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = taa_pkg::bounds_t'(m_tdata);
				if (expected_bounds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: %h", m_tdata);
				end else begin
					want = expected_bounds.pop_front();
					for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
						if (got.lo[a] !== want.lo[a]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("bound_min_%s: expected %h, got %h",
									axis_name[a], want.lo[a], got.lo[a]);
						end
						if (got.hi[a] !== want.hi[a]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("bound_max_%s: expected %h, got %h",
									axis_name[a], want.hi[a], got.hi[a]);
						end
					end
				end
			end
			// Hold ready low for the rest of a stall, else maybe start one
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) stall_left = gap_len();
			end
		end
	end

	// Block until every box is sent and every result has come back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_boxes.size() != 0 || s_tvalid || expected_bounds.size() != 0);
	endtask

	task automatic write_reg(input logic [taa_pkg::CFG_IDX_W-1:0] idx,
			input logic [taa_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx < taa_pkg::NUM_REGS) coef[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_box(input taa_pkg::coord_t nx, input taa_pkg::coord_t ny,
			input taa_pkg::coord_t nz, input taa_pkg::coord_t xx,
			input taa_pkg::coord_t xy, input taa_pkg::coord_t xz,
			input logic restart, input logic xform);
		taa_pkg::item_t it;
		it.bmin[0] = nx;
		it.bmin[1] = ny;
		it.bmin[2] = nz;
		it.bmax[0] = xx;
		it.bmax[1] = xy;
		it.bmax[2] = xz;
		it.restart = restart;
		it.use_transform = xform;
		pending_boxes.push_back(it);
	endtask

	initial begin
		taa_pkg::item_t it;
		int             cfg_mode;
		int             xf_bias;
		for (int i = 0; i < taa_pkg::NUM_REGS; i++) coef[i] = taa_pkg::CFG_RESET[i];
		for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
			run_lo[a] = taa_pkg::POS_MAX;
			run_hi[a] = taa_pkg::NEG_MIN;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Spare indexes must leave the identity matrix untouched
		write_reg(REG_SPARE_LO, 64'hDEAD_BEEF_1234_5678);
		write_reg(REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		@(negedge clk);

		// Identity matrix: empty box after reset, extremes, reversed boxes
		push_box(-32'sh1_0000, -32'sh2_0000, -32'sh3_0000,
			32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 1'b0, 1'b0);
		push_box(taa_pkg::NEG_MIN, taa_pkg::NEG_MIN, taa_pkg::NEG_MIN,
			taa_pkg::POS_MAX, taa_pkg::POS_MAX, taa_pkg::POS_MAX, 1'b0, 1'b0);
		push_box(32'sh5_0000, 32'sh5_0000, 32'sh5_0000,
			-32'sh5_0000, -32'sh5_0000, -32'sh5_0000, 1'b1, 1'b0);
		push_box(32'sh0_8000, -32'sh0_8000, 32'sh0, 32'sh1_0000, 32'sh0, 32'sh1, 1'b0, 1'b0);
		push_box(32'sh1_0000, 32'sh2_0000, 32'sh3_0000,
			32'sh4_0000, 32'sh5_0000, 32'sh6_0000, 1'b1, 1'b1);
		push_box(32'sh9_0000, -32'sh1, 32'sh7, -32'sh9_0000, 32'sh1, -32'sh7, 1'b0, 1'b1);
		push_box(taa_pkg::NEG_MIN, taa_pkg::NEG_MIN, taa_pkg::NEG_MIN,
			taa_pkg::POS_MAX, taa_pkg::POS_MAX, taa_pkg::POS_MAX, 1'b1, 1'b1);
		push_box(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b1);
		wait_idle();

		// Half gains on single LSBs: rounding ties go toward plus infinity
		write_reg(taa_pkg::REG_X_XY,    {32'h0000_8000, 32'h0000_0000});
		write_reg(taa_pkg::REG_X_Z_OFS, {32'h0000_0000, 32'h0000_0000});
		write_reg(taa_pkg::REG_Y_XY,    {32'h0000_0000, 32'hFFFF_8000});
		write_reg(taa_pkg::REG_Y_Z_OFS, {32'h0000_0000, 32'h0000_0001});
		write_reg(taa_pkg::REG_Z_XY,    {32'h0000_0001, 32'h0000_0001});
		write_reg(taa_pkg::REG_Z_Z_OFS, {32'h0001_8000, 32'hFFFF_FFFF});
		@(negedge clk);
		push_box(-32'sh1, -32'sh1, -32'sh1, 32'sh1, 32'sh1, 32'sh1, 1'b1, 1'b1);
		push_box(32'sh3, -32'sh3, 32'sh7, -32'sh3, 32'sh3, -32'sh7, 1'b1, 1'b1);
		push_box(32'sh5, 32'sh2_8001, -32'sh1_7fff, 32'sh11, 32'sh3_0000, 32'sh0, 1'b0, 1'b1);
		push_box(32'sh2, 32'sh2, 32'sh2, 32'sh1, 32'sh1, 32'sh1, 1'b1, 1'b0);
		wait_idle();

		// Largest gains: mapped corners saturate in both directions
		write_reg(taa_pkg::REG_X_XY,    {32'h7FFF_FFFF, 32'h7FFF_FFFF});
		write_reg(taa_pkg::REG_X_Z_OFS, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
		write_reg(taa_pkg::REG_Y_XY,    {32'h8000_0000, 32'h8000_0000});
		write_reg(taa_pkg::REG_Y_Z_OFS, {32'h8000_0000, 32'h8000_0000});
		write_reg(taa_pkg::REG_Z_XY,    {32'hFFFF_FFFF, 32'h0000_0000});
		write_reg(taa_pkg::REG_Z_Z_OFS, {32'h8000_0000, 32'h7FFF_FFFF});
		@(negedge clk);
		push_box(taa_pkg::NEG_MIN, taa_pkg::NEG_MIN, taa_pkg::NEG_MIN,
			taa_pkg::POS_MAX, taa_pkg::POS_MAX, taa_pkg::POS_MAX, 1'b1, 1'b1);
		push_box(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b1);
		push_box(32'sh1, 32'sh1, 32'sh1, 32'sh1, 32'sh1, 32'sh1, 1'b1, 1'b1);
		push_box(taa_pkg::NEG_MIN, taa_pkg::NEG_MIN, taa_pkg::NEG_MIN,
			taa_pkg::NEG_MIN, taa_pkg::NEG_MIN, taa_pkg::NEG_MIN, 1'b1, 1'b1);
		push_box(-32'sh1, 32'sh1_0000, taa_pkg::NEG_MIN,
			32'sh0, taa_pkg::POS_MAX, -32'sh1, 1'b0, 1'b0);
		wait_idle();

		// Random phases: fresh matrix each time, runs of boxes between restarts
		for (int ph = 0; ph < 6; ph++) begin
			cfg_mode = ph % 3;
			quiet = (ph == 3);
			for (int r = 0; r < taa_pkg::NUM_REGS; r++)
				write_reg(taa_pkg::CFG_IDX_W'(r), {rand_q16(cfg_mode), rand_q16(cfg_mode)});
			if (ph == 4) write_reg(REG_SPARE_HI, {$urandom, $urandom});
			@(negedge clk);
			xf_bias = $urandom_range(1, 3);
			for (int n = 0; n < 75; n++) begin
				for (int a = 0; a < taa_pkg::NUM_AXES; a++) begin
					it.bmin[a] = rand_coord();
					it.bmax[a] = rand_coord();
				end
				it.restart = ($urandom_range(0, 7) == 0);
				it.use_transform = ($urandom_range(0, 3) < xf_bias);
				pending_boxes.push_back(it);
			end
			wait_idle();
		end

		// Drain: allow for any stray result to show up
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
